### hdl/console_line_input_defines.svh
// assertion macros shared by the checker
`ifndef CONSOLE_LINE_INPUT_DEFINES_SVH
`define CONSOLE_LINE_INPUT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CLI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console_line_input assertion failed");

// next-cycle implication, disabled while reset is low
`define CLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console_line_input assertion failed");

`endif

### hdl/cli_pkg.sv
package cli_pkg;

    localparam int RING_DEPTH  = 64;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int PTR_W       = RING_AW + 1;
    localparam int MAX_RESULTS = 64;
    localparam int KCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int CFG_IDX_W   = 1;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] EOF_RESET = 8'd4;
    localparam logic [7:0] INT_RESET = 8'd3;

    localparam logic [CFG_IDX_W-1:0] REG_EOF_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INT_CODE = 1'b1;

    typedef enum logic [1:0] {
        REQ_KEY   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_ABORT = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INTR    = 2'd1,
        ST_ABORT   = 2'd2,
        ST_REFUSED = 2'd3
    } t_rd_status;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_REFUSED,
        EMIT_ZERO_LEN,
        EMIT_ABORT
    } t_emit;

    typedef struct packed {
        logic  accept;
        logic  key_in;
        logic  read_start;
        logic  mem_rd;
        logic  drain;
        logic  emit;
        t_emit emit_kind;
        logic  first;
        logic  budget_end;
        logic  abort;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic empty;
        logic len_zero;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic       last;
        logic [7:0] count;
        t_rd_status status;
        logic       done;
        logic [7:0] store_char;
        logic [7:0] store_index;
        logic       store_valid;
        logic [7:0] echo_char;
        logic       echo_valid;
        logic       drop;
    } t_result;

endpackage

### hdl/cli_ram.sv
module cli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cli_ctrl.sv
module cli_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_req_type,
    input  cli_pkg::t_sts i_sts,
    output cli_pkg::t_cmd o_cmd
);
    import cli_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DATA,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [KCNT_W-1:0]   r_kcnt, n_kcnt;
    logic                r_abort, n_abort;
    t_emit               r_kind, n_kind;
    logic [KCNT_W-1:0]   w_budget;

    // an abort keeps one result slot for its own completion
    assign w_budget = r_abort ? KCNT_W'(MAX_RESULTS - 1) : KCNT_W'(MAX_RESULTS);

    always_comb begin
        n_state          = r_state;
        n_kcnt           = r_kcnt;
        n_abort          = r_abort;
        n_kind           = r_kind;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.emit_kind  = r_kind;
        o_cmd.first      = (r_kcnt == '0);
        o_cmd.budget_end = ((r_kcnt + KCNT_W'(1)) == w_budget);
        o_cmd.abort      = r_abort;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_kcnt       = '0;
                    n_abort      = 1'b0;
                    unique case (t_req'(i_req_type))
                        REQ_KEY: begin
                            o_cmd.key_in = 1'b1;
                            n_state      = S_CHECK;
                        end
                        REQ_READ: begin
                            if (i_sts.active) begin
                                n_kind  = EMIT_REFUSED;
                                n_state = S_EMIT;
                            end else if (i_sts.len_zero) begin
                                n_kind  = EMIT_ZERO_LEN;
                                n_state = S_EMIT;
                            end else begin
                                o_cmd.read_start = 1'b1;
                                n_state          = S_CHECK;
                            end
                        end
                        REQ_ABORT: begin
                            if (i_sts.active) begin
                                n_abort = 1'b1;
                                n_state = S_CHECK;
                            end else begin
                                n_kind  = EMIT_NONE;
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                            n_kind  = EMIT_NONE;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (i_sts.active && !i_sts.empty && (r_kcnt < w_budget)) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_DATA;
                end else if (r_abort && i_sts.active) begin
                    n_kind  = EMIT_ABORT;
                    n_state = S_EMIT;
                end else if (r_kcnt == '0) begin
                    // nothing reported yet: one empty word closes the item
                    n_kind  = EMIT_NONE;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DATA: begin
                if (i_sts.out_free) begin
                    o_cmd.drain = 1'b1;
                    n_kcnt      = r_kcnt + KCNT_W'(1);
                    n_state     = S_CHECK;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kcnt  <= '0;
            r_abort <= 1'b0;
            r_kind  <= EMIT_NONE;
        end else begin
            r_state <= n_state;
            r_kcnt  <= n_kcnt;
            r_abort <= n_abort;
            r_kind  <= n_kind;
        end
    end

endmodule

### hdl/cli_datapath.sv
module cli_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cli_pkg::t_cmd                    i_cmd,
    output cli_pkg::t_sts                    o_sts,
    input  logic [7:0]                       i_key_char,
    input  logic [7:0]                       i_read_len,
    input  logic                             i_cfg_we,
    input  logic [cli_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [7:0]                       i_cfg_wdata,
    output cli_pkg::t_result                 o_res,
    output logic                             o_res_valid,
    input  logic                             i_res_ready
);
    import cli_pkg::*;

    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic             r_active, n_active;
    logic [7:0]       r_left, n_left;
    logic [7:0]       r_stored, n_stored;
    logic [7:0]       r_eof, n_eof;
    logic [7:0]       r_intr, n_intr;
    logic             r_drop, n_drop;
    logic             r_res_valid, n_res_valid;
    t_result          r_res, n_res;

    logic             w_full;
    logic             w_ram_we;
    logic [7:0]       w_char;
    logic [PTR_W-1:0] w_rp_inc;
    logic             w_fin;
    t_result          w_res;

    // gap of one full ring between the pointers means full
    assign w_full   = (r_wp[PTR_W-1] != r_rp[PTR_W-1]) &&
                      (r_wp[RING_AW-1:0] == r_rp[RING_AW-1:0]);
    assign w_ram_we = i_cmd.key_in && !w_full;
    assign w_rp_inc = r_rp + PTR_W'(1);

    cli_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp[RING_AW-1:0]),
        .i_wdata (i_key_char),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (r_rp[RING_AW-1:0]),
        .o_rdata (w_char)
    );

    always_comb begin
        o_sts.active   = r_active;
        o_sts.empty    = (r_wp == r_rp);
        o_sts.len_zero = (i_read_len == 8'd0);
        o_sts.out_free = !r_res_valid || i_res_ready;
    end

    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_active    = r_active;
        n_left      = r_left;
        n_stored    = r_stored;
        n_eof       = r_eof;
        n_intr      = r_intr;
        n_drop      = r_drop;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        w_res       = '0;
        w_fin       = 1'b0;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EOF_CODE: n_eof  = i_cfg_wdata;
                REG_INT_CODE: n_intr = i_cfg_wdata;
                default:      n_eof  = r_eof;
            endcase
        end

        if (i_cmd.accept) begin
            n_drop = i_cmd.key_in && w_full;
        end
        if (w_ram_we) begin
            n_wp = r_wp + PTR_W'(1);
        end
        if (i_cmd.read_start) begin
            n_active = 1'b1;
            n_left   = i_read_len;
            n_stored = 8'd0;
        end

        if (i_cmd.drain) begin
            n_rp = w_rp_inc;
            if (w_char == r_eof) begin
                w_res.done   = 1'b1;
                w_res.status = ST_OK;
                w_res.count  = r_stored;
                w_fin        = 1'b1;
            end else if (w_char == r_intr) begin
                w_res.done   = 1'b1;
                w_res.status = ST_INTR;
                w_fin        = 1'b1;
            end else if (w_char == CH_BS) begin
                if (r_stored != 8'd0) begin
                    n_stored         = r_stored - 8'd1;
                    n_left           = r_left + 8'd1;
                    w_res.echo_valid = 1'b1;
                    w_res.echo_char  = w_char;
                end
            end else if (w_char == CH_NL) begin
                w_res.echo_valid = 1'b1;
                w_res.echo_char  = w_char;
                w_res.done       = 1'b1;
                w_res.status     = ST_OK;
                w_res.count      = r_stored;
                w_fin            = 1'b1;
            end else begin
                w_res.echo_valid  = 1'b1;
                w_res.echo_char   = w_char;
                w_res.store_valid = 1'b1;
                w_res.store_index = r_stored;
                w_res.store_char  = w_char;
                n_stored          = r_stored + 8'd1;
                n_left            = r_left - 8'd1;
                // line full once the last allowed byte is stored
                if (r_left == 8'd1) begin
                    w_res.done   = 1'b1;
                    w_res.status = ST_OK;
                    w_res.count  = r_stored + 8'd1;
                    w_fin        = 1'b1;
                end
            end
            if (w_fin) begin
                n_active = 1'b0;
                n_left   = 8'd0;
            end
            w_res.drop  = r_drop && i_cmd.first;
            w_res.last  = w_fin ||
                          (!i_cmd.abort && ((w_rp_inc == r_wp) || i_cmd.budget_end));
            n_res       = w_res;
            n_res_valid = 1'b1;
        end

        if (i_cmd.emit) begin
            w_res.drop = r_drop && i_cmd.first;
            w_res.last = 1'b1;
            unique case (i_cmd.emit_kind)
                EMIT_NONE: begin
                    w_res.done = 1'b0;
                end
                EMIT_REFUSED: begin
                    w_res.done   = 1'b1;
                    w_res.status = ST_REFUSED;
                end
                EMIT_ZERO_LEN: begin
                    w_res.done   = 1'b1;
                    w_res.status = ST_OK;
                end
                EMIT_ABORT: begin
                    w_res.done   = 1'b1;
                    w_res.status = ST_ABORT;
                    n_active     = 1'b0;
                    n_left       = 8'd0;
                end
                default: begin
                    w_res.done = 1'b0;
                end
            endcase
            n_res       = w_res;
            n_res_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_active    <= 1'b0;
            r_left      <= 8'd0;
            r_stored    <= 8'd0;
            r_eof       <= EOF_RESET;
            r_intr      <= INT_RESET;
            r_drop      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_active    <= n_active;
            r_left      <= n_left;
            r_stored    <= n_stored;
            r_eof       <= n_eof;
            r_intr      <= n_intr;
            r_drop      <= n_drop;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

### hdl/console_line_input.sv
// console line input: keyboard bytes and line-read requests in, echo/store/done words out
// input stream: tuser carries the request kind (0 key byte, 1 start read, 2 abort),
//   tdata carries key_char and read_len; one item is taken while the block is idle
// output stream: one word per echoed, stored or discarded byte plus read completions;
//   tlast marks the final word caused by an input item, every item gives at least one
// config port: write-only, index 0 eof code (reset 4), index 1 interrupt code (reset 3)
// sequence: a refused or zero-length read, an abort with no read active and an unused kind
//   go from accept straight to the emit state, which loads their single word; other items
//   first pass through a check of the ring, and each byte drained from the 64-byte ring
//   takes a check state (for the registered ring memory read) and a data state (to
//   evaluate and load the output word); both load states wait while the output is stalled
// a key byte with an active read and an empty ring is written to the ring, read back and drained
// tready comes back in the cycle after the last word of an item is loaded, or after a
//   further check state when that word carries a drained byte; the word may still wait in
//   the output register
// reset: pointers, read state and output valid clear, config codes return
//   to their defaults; ring contents are not cleared and need no clearing pass
// a stalled receiver holds the output word and stops draining; queued keys then wait
module console_line_input (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [15:0]                   i_s_axis_tdata,  // key_char, read_len
    input  logic [1:0]                    i_s_axis_tuser,  // req_type
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // echo_char, store_index, store_char, read_status, read_count, zero pad
    output logic [39:0]                   o_m_axis_tdata,
    // key_dropped, echo_valid, store_valid, read_done
    output logic [3:0]                    o_m_axis_tuser,
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [cli_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_wdata
);
    import cli_pkg::*;

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_result w_res;

    cli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_req_type (i_s_axis_tuser),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cli_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_key_char  (i_s_axis_tdata[7:0]),
        .i_read_len  (i_s_axis_tdata[15:8]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (w_res),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {6'd0, w_res.count, w_res.status, w_res.store_char,
                             w_res.store_index, w_res.echo_char};
    assign o_m_axis_tuser = {w_res.done, w_res.store_valid, w_res.echo_valid, w_res.drop};
    assign o_m_axis_tlast = w_res.last;

endmodule

### hdl/cli_checker.sv
`include "console_line_input_defines.svh"

module cli_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [15:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast,
    input logic        i_cfg_we,
    input logic [0:0]  i_cfg_idx,
    input logic [7:0]  i_cfg_wdata
);

    // a finished read is always the closing word of its item
    `CLI_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser[3], o_m_axis_tlast)

    // a stored byte is echoed as the same byte
    `CLI_ASSERT_NOW(a_store_echoes, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser[2],
        o_m_axis_tuser[1] && (o_m_axis_tdata[7:0] == o_m_axis_tdata[23:16]))

    // interrupted, aborted and refused reads report no bytes
    `CLI_ASSERT_NOW(a_error_count_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser[3] && (o_m_axis_tdata[25:24] != 2'd0),
        o_m_axis_tdata[33:26] == 8'd0)

    // the block is busy in the cycle after it takes an item
    `CLI_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // a stalled output word stays offered
    `CLI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

endmodule

bind console_line_input cli_checker u_cli_checker (.*);

### test/console_echo_checker.sv
module console_echo_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [15:0]                   i_in_data,   // key_char, read_len
    input  logic [1:0]                    i_in_kind,   // req_type
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    // echo_char, store_index, store_char, read_status, read_count, zero pad
    input  logic [39:0]                   i_out_data,
    // key_dropped, echo_valid, store_valid, read_done
    input  logic [3:0]                    i_out_flags,
    input  logic                          i_out_last,
    input  logic                          i_cfg_we,
    input  logic [cli_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_wdata,
    output int                            o_pending,
    output int                            o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    import cli_pkg::*;

    // own copy of the keyboard ring and the line reader
    logic [7:0]       ring_mem [RING_DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic             line_active;
    logic [7:0]       room_left;
    logic [7:0]       line_count;
    logic [7:0]       eof_char;
    logic [7:0]       intr_char;

    t_result item_words [$];
    t_result awaited [$];
    int      mismatch_count = 0;

    function automatic t_result close_line(t_result w, t_rd_status st, logic [7:0] cnt);
        w.done      = 1'b1;
        w.status    = st;
        w.count     = cnt;
        line_active = 1'b0;
        room_left   = '0;
        return w;
    endfunction

    // pull buffered bytes into the active line, one word per byte
    function automatic void drain_ring(int budget);
        t_result    w;
        logic [7:0] c;
        while (line_active && rd_ptr != wr_ptr && item_words.size() < budget) begin
            c      = ring_mem[rd_ptr[RING_AW-1:0]];
            rd_ptr = rd_ptr + PTR_W'(1);
            w      = '0;
            if (c == eof_char) begin
                w = close_line(w, ST_OK, line_count);
            end else if (c == intr_char) begin
                w = close_line(w, ST_INTR, 8'd0);
            end else if (c == CH_BS) begin
                // rubout only takes effect when the line holds something
                if (line_count != 8'd0) begin
                    line_count   = line_count - 8'd1;
                    room_left    = room_left + 8'd1;
                    w.echo_valid = 1'b1;
                    w.echo_char  = c;
                end
            end else if (c == CH_NL) begin
                w.echo_valid = 1'b1;
                w.echo_char  = c;
                w = close_line(w, ST_OK, line_count);
            end else begin
                w.echo_valid  = 1'b1;
                w.echo_char   = c;
                w.store_valid = 1'b1;
                w.store_index = line_count;
                w.store_char  = c;
                line_count    = line_count + 8'd1;
                room_left     = room_left - 8'd1;
                if (room_left == 8'd0) w = close_line(w, ST_OK, line_count);
            end
            item_words.push_back(w);
        end
    endfunction

    function automatic void predict_item(logic [1:0] kind, logic [7:0] key, logic [7:0] len);
        logic             dropped;
        logic [PTR_W-1:0] fill;
        t_result          w;
        dropped = 1'b0;
        fill    = wr_ptr - rd_ptr;
        item_words.delete();
        case (kind)
            REQ_KEY: begin
                if (fill == PTR_W'(RING_DEPTH)) begin
                    dropped = 1'b1;
                end else begin
                    ring_mem[wr_ptr[RING_AW-1:0]] = key;
                    wr_ptr = wr_ptr + PTR_W'(1);
                end
                drain_ring(MAX_RESULTS);
            end
            REQ_READ: begin
                w = '0;
                if (line_active) begin
                    w.done   = 1'b1;
                    w.status = ST_REFUSED;
                    item_words.push_back(w);
                end else if (len == 8'd0) begin
                    w.done = 1'b1;
                    item_words.push_back(w);
                end else begin
                    line_active = 1'b1;
                    room_left   = len;
                    line_count  = '0;
                    drain_ring(MAX_RESULTS);
                end
            end
            REQ_ABORT: begin
                if (line_active) begin
                    // one slot kept back for the abort word itself
                    drain_ring(MAX_RESULTS - 1);
                    if (line_active) item_words.push_back(close_line('0, ST_ABORT, 8'd0));
                end
            end
            default: ;
        endcase
        if (item_words.size() == 0) item_words.push_back('0);
        if (dropped) item_words[0].drop = 1'b1;
        item_words[item_words.size()-1].last = 1'b1;
        foreach (item_words[i]) awaited.push_back(item_words[i]);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void compare_word(t_result want, t_result got);
        check_field("key_dropped", want.drop, got.drop);
        check_field("echo_valid", want.echo_valid, got.echo_valid);
        check_field("echo_char", want.echo_char, got.echo_char);
        check_field("store_valid", want.store_valid, got.store_valid);
        check_field("store_index", want.store_index, got.store_index);
        check_field("store_char", want.store_char, got.store_char);
        check_field("read_done", want.done, got.done);
        check_field("read_status", want.status, got.status);
        check_field("read_count", want.count, got.count);
        check_field("last", want.last, got.last);
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        if (!i_rst_n) begin
            wr_ptr      = '0;
            rd_ptr      = '0;
            line_active = 1'b0;
            room_left   = '0;
            line_count  = '0;
            eof_char    = EOF_RESET;
            intr_char   = INT_RESET;
            awaited.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_EOF_CODE) eof_char = i_cfg_wdata;
                else if (i_cfg_idx == REG_INT_CODE) intr_char = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                seen             = '0;
                seen.echo_char   = i_out_data[7:0];
                seen.store_index = i_out_data[15:8];
                seen.store_char  = i_out_data[23:16];
                seen.status      = t_rd_status'(i_out_data[25:24]);
                seen.count       = i_out_data[33:26];
                seen.drop        = i_out_flags[0];
                seen.echo_valid  = i_out_flags[1];
                seen.store_valid = i_out_flags[2];
                seen.done        = i_out_flags[3];
                seen.last        = i_out_last;
                if (awaited.size() == 0) begin
                    $display("%0t: expected nothing actual word %h flags %b last %b",
                             $time, i_out_data, i_out_flags, i_out_last);
                    mismatch_count++;
                end else begin
                    compare_word(awaited.pop_front(), seen);
                end
            end
            if (i_in_valid && i_in_ready)
                predict_item(i_in_kind, i_in_data[7:0], i_in_data[15:8]);
        end
        o_pending <= awaited.size();
        o_errors  <= mismatch_count;
    end

endmodule

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cli_pkg::*;

    localparam int PHASE_ITEMS = 40;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [39:0]          m_tdata;
    logic [3:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [7:0]           cfg_wdata = '0;

    int         pending;
    int         errors;
    int         sent     = 0;
    bit         steady   = 1'b0;   // no idling on either side
    logic [7:0] cur_eof  = EOF_RESET;
    logic [7:0] cur_intr = INT_RESET;

    console_line_input u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    console_echo_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (s_tvalid),
        .i_in_ready  (s_tready),
        .i_in_data   (s_tdata),
        .i_in_kind   (s_tuser),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_data  (m_tdata),
        .i_out_flags (m_tuser),
        .i_out_last  (m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random stall before each word
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_word(input logic [1:0] req, input logic [7:0] key,
                             input logic [7:0] len);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {len, key};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        if (req != 2'd3) sent++;
    endtask

    // hold off until every word owed has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] plain_key();
        logic [7:0] c;
        do c = 8'($urandom_range(32, 126)); while (c == cur_eof || c == cur_intr);
        return c;
    endfunction

    task automatic type_line();
        int         n;
        int         pick;
        logic [7:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 70) len = 8'($urandom_range(1, 16));
        else if (pick < 90) len = 8'($urandom_range(17, 80));
        else len = 8'd255;
        // type-ahead before the read is posted
        repeat ($urandom_range(0, 3)) send_word(REQ_KEY, plain_key(), 8'($urandom));
        send_word(REQ_READ, 8'($urandom), len);
        n = $urandom_range(0, 20);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) send_word(REQ_KEY, plain_key(), 8'($urandom));
            else if (pick < 92) send_word(REQ_KEY, CH_BS, 8'($urandom));
            else send_word(REQ_KEY, 8'($urandom), 8'($urandom));
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) send_word(REQ_KEY, CH_NL, 8'($urandom));
        else if (pick < 65) send_word(REQ_KEY, cur_eof, 8'($urandom));
        else if (pick < 75) send_word(REQ_KEY, cur_intr, 8'($urandom));
        else if (pick < 85) send_word(REQ_ABORT, 8'($urandom), 8'($urandom));
    endtask

    // overfill the ring with no reader, then drain it in one read
    task automatic fill_ring();
        send_word(REQ_ABORT, 8'($urandom), 8'($urandom));
        repeat (RING_DEPTH + $urandom_range(1, 4))
            send_word(REQ_KEY, plain_key(), 8'($urandom));
        send_word(REQ_READ, 8'($urandom), 8'd255);
        send_word(REQ_ABORT, 8'($urandom), 8'($urandom));
    endtask

    task automatic random_phase(input int target);
        int pick;
        int start;
        start = sent;
        while (sent - start < target) begin
            if ($urandom_range(0, 9) == 0) steady = !steady;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                type_line();
            end else if (pick < 68) begin
                fill_ring();
            end else if (pick < 73) begin
                settle();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] eof_value, input logic [7:0] intr_value,
                             input bit with_fill);
        settle();
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_EOF_CODE;
        cfg_wdata <= eof_value;
        @(posedge clk);
        cfg_idx   <= REG_INT_CODE;
        cfg_wdata <= intr_value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_eof  = eof_value;
        cur_intr = intr_value;
        if (with_fill) fill_ring();
        random_phase(PHASE_ITEMS);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset codes
        send_word(REQ_READ, 8'h00, 8'd0);           // zero length read
        send_word(REQ_KEY, 8'h61, 8'h00);           // buffered, no reader
        send_word(REQ_KEY, 8'hff, 8'hff);
        send_word(REQ_KEY, 8'h00, 8'h00);
        send_word(REQ_READ, 8'hff, 8'd255);         // drains the three
        send_word(REQ_READ, 8'h00, 8'd5);           // refused while active
        send_word(REQ_KEY, CH_BS, 8'h00);
        send_word(REQ_KEY, CH_NL, 8'h00);
        send_word(REQ_ABORT, 8'h00, 8'h00);         // no reader, ignored
        send_word(2'd3, 8'h55, 8'haa);              // unused kind
        send_word(REQ_READ, 8'h00, 8'd2);           // ends on length
        send_word(REQ_KEY, 8'h78, 8'h00);
        send_word(REQ_KEY, 8'h79, 8'h00);
        send_word(REQ_READ, 8'h00, 8'd10);
        send_word(REQ_KEY, CH_BS, 8'h00);           // rubout on empty line
        send_word(REQ_KEY, EOF_RESET, 8'h00);
        send_word(REQ_READ, 8'h00, 8'd10);
        send_word(REQ_KEY, 8'h7a, 8'h00);
        send_word(REQ_KEY, INT_RESET, 8'h00);
        send_word(REQ_READ, 8'h00, 8'd10);
        send_word(REQ_ABORT, 8'h00, 8'h00);         // abort a waiting read
        settle();
        random_phase(PHASE_ITEMS);

        run_phase(8'd0, 8'd255, 1'b1);
        run_phase(8'd255, 8'd0, 1'b0);
        run_phase(CH_NL, CH_BS, 1'b0);              // codes shadow newline and rubout
        run_phase(8'h71, 8'h71, 1'b0);              // eof wins over interrupt
        settle();

        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
